/* rtl/core/battery_level_estimator_macros.svh */
`ifndef BATTERY_LEVEL_ESTIMATOR_MACROS_SVH
`define BATTERY_LEVEL_ESTIMATOR_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define BLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ble_pkg.sv */
package ble_pkg;

  localparam int ADC_BITS = 12;

  // Field widths
  localparam int MV_W    = 13;
  localparam int PCT_W   = 7;
  localparam int STEP_W  = 12;
  localparam int LEVEL_W = 16;
  localparam int FRAC_W  = 8;

  // Scaling to millivolts
  localparam int PROD_W = ADC_BITS + MV_W;
  localparam logic [MV_W-1:0] MV_SCALE = MV_W'(6000);

  // Knees of the discharge curve, mV
  localparam logic [MV_W-1:0] MV_KNEE0 = MV_W'(3300);
  localparam logic [MV_W-1:0] MV_KNEE1 = MV_W'(3500);
  localparam logic [MV_W-1:0] MV_KNEE2 = MV_W'(3600);
  localparam logic [MV_W-1:0] MV_KNEE3 = MV_W'(3800);
  localparam logic [MV_W-1:0] MV_KNEE4 = MV_W'(3900);

  // Segment numerator, offset and reciprocal divide
  localparam int X_W         = 12;
  localparam int OFF_W       = 7;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int Q_W         = X_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(6554);
  localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(3277);

  localparam logic [OFF_W-1:0] OFF_LOW  = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_SEG1 = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_SEG2 = OFF_W'(10);
  localparam logic [OFF_W-1:0] OFF_SEG3 = OFF_W'(20);
  localparam logic [OFF_W-1:0] OFF_SEG4 = OFF_W'(80);
  localparam logic [OFF_W-1:0] OFF_SEG5 = OFF_W'(90);

  localparam logic [PCT_W-1:0] PCT_CAP = PCT_W'(100);

  // Smoothed level
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(16'h7FFF);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(26);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    DIV_BY_10,
    DIV_BY_20
  } ble_div_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  mv;
  } ble_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } ble_qstat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               first;
  } ble_bstat_t;

endpackage

/* rtl/core/ble_in_if.sv */
interface ble_in_if import ble_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

/* rtl/core/ble_out_if.sv */
interface ble_out_if import ble_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] level_percent;
  logic [MV_W-1:0]  voltage_mv;

  modport source (output valid, output level_percent, output voltage_mv, input ready);
  modport sink   (input valid, input level_percent, input voltage_mv, output ready);
endinterface

/* rtl/core/ble_front.sv */
module ble_front import ble_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ble_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      push,
  output ble_item_t push_item
);

  logic ready_a, ready_b, ready_c;

  // Stage A: raw product
  logic              a_v_r;
  logic [PROD_W-1:0] a_prod_r;

  // Stage B: segment selected
  logic             b_v_r;
  logic [X_W-1:0]   b_x_r;
  ble_div_t         b_div_r;
  logic [OFF_W-1:0] b_off_r;
  logic [MV_W-1:0]  b_mv_r;

  // Stage C: finished item
  logic      c_v_r;
  ble_item_t c_item_r;

  logic [MV_W-1:0]  mv_raw, mv, seg_base, d;
  logic [X_W-1:0]   d_x, x_nxt;
  logic [X_W+1:0]   d3;
  ble_div_t         div_nxt;
  logic [OFF_W-1:0] off_nxt;
  logic             low, triple;

  logic [RECIP_W-1:0]     recip;
  logic [X_W+RECIP_W-1:0] qprod;
  logic [Q_W-1:0]         q, pct_sum;
  logic [PCT_W-1:0]       pct;

  assign ready_c     = !c_v_r || !q_full;
  assign ready_b     = !b_v_r || ready_c;
  assign ready_a     = !a_v_r || ready_b;
  assign in_ch.ready = ready_a;

  assign push      = c_v_r && !q_full;
  assign push_item = c_item_r;

  always_comb begin
    mv_raw   = a_prod_r[ADC_BITS +: MV_W];
    mv       = (mv_raw == '0) ? MV_W'(1) : mv_raw;
    seg_base = MV_KNEE0;
    div_nxt  = DIV_BY_20;
    off_nxt  = OFF_SEG1;
    low      = 1'b0;
    triple   = 1'b0;
    if (mv < MV_KNEE0) begin
      low     = 1'b1;
      off_nxt = OFF_LOW;
    end else if (mv < MV_KNEE1) begin
      seg_base = MV_KNEE0;
      div_nxt  = DIV_BY_20;
      off_nxt  = OFF_SEG1;
    end else if (mv < MV_KNEE2) begin
      seg_base = MV_KNEE1;
      div_nxt  = DIV_BY_10;
      off_nxt  = OFF_SEG2;
    end else if (mv < MV_KNEE3) begin
      seg_base = MV_KNEE2;
      div_nxt  = DIV_BY_10;
      off_nxt  = OFF_SEG3;
      triple   = 1'b1;
    end else if (mv < MV_KNEE4) begin
      seg_base = MV_KNEE3;
      div_nxt  = DIV_BY_10;
      off_nxt  = OFF_SEG4;
    end else begin
      seg_base = MV_KNEE4;
      div_nxt  = DIV_BY_20;
      off_nxt  = OFF_SEG5;
    end
    d   = mv - seg_base;
    d_x = d[X_W-1:0];
    d3  = {1'b0, d_x, 1'b0} + {2'b00, d_x};
    if (low) begin
      x_nxt = '0;
    end else if (triple) begin
      x_nxt = d3[X_W-1:0];
    end else begin
      x_nxt = d_x;
    end
  end

  // Divide by ten or twenty through a reciprocal; exact over each segment's range
  always_comb begin
    recip   = (b_div_r == DIV_BY_10) ? RECIP_10 : RECIP_20;
    qprod   = (X_W+RECIP_W)'(b_x_r) * (X_W+RECIP_W)'(recip);
    q       = qprod[RECIP_SHIFT +: Q_W];
    pct_sum = q + Q_W'(b_off_r);
    pct     = (pct_sum > Q_W'(PCT_CAP)) ? PCT_CAP : pct_sum[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (ready_a) a_v_r <= in_ch.valid;
      if (ready_b) b_v_r <= a_v_r;
      if (ready_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_ch.valid) begin
      a_prod_r <= PROD_W'(in_ch.adc_code) * PROD_W'(MV_SCALE);
    end
    if (ready_b && a_v_r) begin
      b_x_r   <= x_nxt;
      b_div_r <= div_nxt;
      b_off_r <= off_nxt;
      b_mv_r  <= mv;
    end
    if (ready_c && b_v_r) begin
      c_item_r.pct <= pct;
      c_item_r.mv  <= b_mv_r;
    end
  end

endmodule

/* rtl/core/ble_queue.sv */
module ble_queue import ble_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ble_item_t  push_item,
  input  logic       pop,
  output ble_item_t  head,
  output ble_qstat_t stat
);

  ble_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign head       = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

/* rtl/core/ble_back.sv */
module ble_back import ble_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,
  input  logic              q_empty,
  input  ble_item_t         head,
  output logic              pop,
  ble_out_if.source         out_ch,
  output ble_bstat_t        stat
);

  logic [STEP_W-1:0]  step_r;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               first_r;
  logic               out_v_r;
  logic [PCT_W-1:0]   out_pct_r, pct_nxt;
  logic [MV_W-1:0]    out_mv_r;

  logic [LEVEL_W-1:0] target;
  logic [LEVEL_W:0]   up;

  assign pop = !q_empty && (!out_v_r || out_ch.ready);

  assign out_ch.valid         = out_v_r;
  assign out_ch.level_percent = out_pct_r;
  assign out_ch.voltage_mv    = out_mv_r;

  assign stat.level = level_r;
  assign stat.first = first_r;

  always_comb begin
    target = LEVEL_W'({head.pct, {FRAC_W{1'b0}}});
    up     = (LEVEL_W+1)'(level_r) + (LEVEL_W+1)'({step_r, 1'b0});
    if (first_r) begin
      level_nxt = target;
    end else if (target > level_r) begin
      level_nxt = (up > (LEVEL_W+1)'(LEVEL_MAX)) ? LEVEL_MAX : up[LEVEL_W-1:0];
    end else if (target < level_r) begin
      // drop by one step, floor at zero
      level_nxt = (LEVEL_W'(step_r) > level_r) ? '0 : level_r - LEVEL_W'(step_r);
    end else begin
      level_nxt = level_r;
    end
    pct_nxt = first_r ? head.pct : level_nxt[FRAC_W +: PCT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RESET;
      level_r <= '0;
      first_r <= 1'b1;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) step_r <= cfg_wdata;
      if (pop) begin
        level_r <= level_nxt;
        first_r <= 1'b0;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_pct_r <= pct_nxt;
      out_mv_r  <= head.mv;
    end
  end

endmodule

/* rtl/core/battery_level_estimator.sv */
// Battery level estimator: each item carries one raw converter sample and yields
// one result holding the battery voltage in mV and a smoothed lithium-ion charge
// level in percent. One item is taken every clock cycle when the result side keeps
// up; items pass three front stages (scaling, curve segment, reciprocal divide),
// a four-entry queue and the output register. The level update is combinational
// add and compare logic in the back end, so it sets no limit on rate. A full queue
// stalls input only once the result side is held off until the queue fills.
// smoothing_step resets to 26 and is written through cfg_we/cfg_wdata; the user
// must write it only while no item is in flight: the block does not enforce this.
`include "battery_level_estimator_macros.svh"

module battery_level_estimator import ble_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ble_in_if.sink            in_ch,
  ble_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata
);

  logic       push, pop;
  ble_item_t  push_item, head;
  ble_qstat_t qstat;
  ble_bstat_t bstat;

  ble_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (qstat.full),
    .push      (push),
    .push_item (push_item)
  );

  ble_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  ble_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (qstat.empty),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch),
    .stat      (bstat)
  );

  `BLE_ASSERT_ALWAYS(a_queue_bound, qstat.count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `BLE_ASSERT_NEXT(a_queue_fill, push && !pop, qstat.count == $past(qstat.count) + 1'b1, "queue count slip on push")
  `BLE_ASSERT_ALWAYS(a_level_sat, bstat.level <= LEVEL_MAX, "smoothed level above saturation")
  `BLE_ASSERT_NEXT(a_first_once, !bstat.first, !bstat.first, "first-item flag set again")

endmodule

/* test/ble_level_checker.sv */
`timescale 1ns / 1ps

module ble_level_checker import ble_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ble_in_if                 in_ch,
  ble_out_if                out_ch,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending_results
);

  localparam int REPORT_LIMIT = 30;

  logic [STEP_W-1:0]  step_q;
  logic [LEVEL_W-1:0] level_q;
  logic               awaiting_first;
  ble_item_t          expected_q[$];

  function automatic logic [MV_W-1:0] code_to_mv(logic [ADC_BITS-1:0] code);
    int unsigned mv;
    mv = (int'(code) * 6000) >> ADC_BITS;
    return (mv > 1) ? MV_W'(mv) : MV_W'(1);
  endfunction

  // Five-segment discharge curve of a lithium-ion cell
  function automatic int unsigned mv_to_charge(int unsigned v);
    int unsigned p;
    if (v < 3300) return 1;
    if (v < 3500)      p = (v - 3300) * 10 / 200;
    else if (v < 3600) p = (v - 3500) / 10 + 10;
    else if (v < 3800) p = (v - 3600) * 60 / 200 + 20;
    else if (v < 3900) p = (v - 3800) / 10 + 80;
    else               p = (v - 3900) * 10 / 200 + 90;
    return (p > 100) ? 100 : p;
  endfunction

  // Advance the smoothed level for one sample and form the result it gives
  function automatic ble_item_t predict_item(logic [ADC_BITS-1:0] code);
    ble_item_t   res;
    int unsigned mv;
    int unsigned pct;
    int unsigned target;
    int unsigned lvl;
    mv     = code_to_mv(code);
    pct    = mv_to_charge(mv);
    target = pct << 8;
    lvl    = level_q;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      lvl     = target;
      res.pct = PCT_W'(pct);
    end else begin
      if (target > lvl) begin
        lvl = (lvl + 2 * step_q > LEVEL_MAX) ? LEVEL_MAX : lvl + 2 * step_q;
      end else if (target < lvl) begin
        lvl = (step_q > lvl) ? 0 : lvl - step_q;
      end
      res.pct = PCT_W'(lvl >> 8);
    end
    level_q = LEVEL_W'(lvl);
    res.mv  = MV_W'(mv);
    return res;
  endfunction

  always @(posedge clk) begin : track
    ble_item_t exp_item;
    if (!rst_n) begin
      step_q         = STEP_RESET;
      level_q        = '0;
      awaiting_first = 1'b1;
      fail_count     = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        step_q = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_item(in_ch.adc_code));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: unexpected result: expected none, got level %0d mv %0d",
                     $time, out_ch.level_percent, out_ch.voltage_mv);
          end
          fail_count++;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_ch.level_percent !== exp_item.pct || out_ch.voltage_mv !== exp_item.mv) begin
            if (fail_count < REPORT_LIMIT) begin
              if (out_ch.level_percent !== exp_item.pct) begin
                $display("%0t: level_percent mismatch: expected %0d, got %0d",
                         $time, exp_item.pct, out_ch.level_percent);
              end
              if (out_ch.voltage_mv !== exp_item.mv) begin
                $display("%0t: voltage_mv mismatch: expected %0d, got %0d",
                         $time, exp_item.mv, out_ch.voltage_mv);
              end
            end
            fail_count++;
          end
        end
      end
    end
    pending_results = expected_q.size();
  end

endmodule

/* test/tb_battery_level_estimator.sv */
`timescale 1ns / 1ps

module tb_battery_level_estimator;
  import ble_pkg::*;

  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam logic [ADC_BITS-1:0] ZERO_PCT_CODE = 12'd2253;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending_results;
  int                quiet_cycles;
  int                walk_code = 2400;
  bit                tx_idle;
  bit                rx_idle;
  bit                hold_off_req;

  // Knees of the curve, the zero-percent band, the cap and bit patterns
  logic [ADC_BITS-1:0] knee_codes[$] = '{
    12'h000, 12'h000, 12'hFFF, 12'h001, 12'd2252, 12'd2253, 12'd2266, 12'd2390,
    12'd2458, 12'd2594, 12'd2595, 12'd2663, 12'd2799, 12'hAAA, 12'h555, 12'd2400
  };

  ble_in_if  in_ch();
  ble_out_if out_ch();

  battery_level_estimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ble_level_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #1 clk = ~clk;

  function automatic int idle_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Half the time a slow walk across the curve so the level can track it
  function automatic logic [ADC_BITS-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      walk_code = walk_code + int'($urandom_range(0, 64)) - 32;
      if (walk_code < 2200) walk_code = 2200;
      if (walk_code > 2880) walk_code = 2880;
      return ADC_BITS'(walk_code);
    end
    if (r < 80) return ADC_BITS'($urandom_range(0, 4095));
    if (r < 92) return ADC_BITS'($urandom_range(2240, 2880));
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  task automatic send_sample(logic [ADC_BITS-1:0] code, int gap);
    in_ch.valid    <= 1'b1;
    in_ch.adc_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_random(int count);
    repeat (count) send_sample(pick_code(), idle_gap(tx_idle));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] step_val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= step_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        gap = idle_gap(rx_idle);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL battery_level_estimator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.adc_code = '0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    hold_off_req   = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (knee_codes[i]) send_sample(knee_codes[i], 0);

    // Hold the result side off and keep offering until the input stalls
    hold_off_req = 1'b1;
    repeat (30) send_sample(pick_code(), 0);
    wait_drained();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(150);
    rx_idle = 1'b0;
    run_random(40);

    // Largest step: drive the level into both saturation limits
    write_step(12'd4095);
    tx_idle = 1'b0;
    repeat (5) send_sample(12'hFFF, 0);
    repeat (10) send_sample(ZERO_PCT_CODE, 0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(120);

    write_step(12'd0);
    run_random(80);

    write_step(12'd1);
    tx_idle = 1'b0;
    run_random(100);

    repeat (3) begin
      write_step(STEP_W'($urandom_range(2, 4094)));
      tx_idle = $urandom_range(0, 1);
      rx_idle = $urandom_range(0, 1);
      run_random(80);
    end

    write_step(12'd128);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(80);

    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS battery_level_estimator");
    end else begin
      $display("FAIL battery_level_estimator");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ble_pkg.sv
rtl/core/ble_in_if.sv
rtl/core/ble_out_if.sv
rtl/core/ble_front.sv
rtl/core/ble_queue.sv
rtl/core/ble_back.sv
rtl/core/battery_level_estimator.sv
test/ble_level_checker.sv
test/tb_battery_level_estimator.sv
